### rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and sizes of the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int TASK_SLOTS  = 32;
   localparam int MAX_RESULTS = 32;

   localparam int IDX_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int TOTAL_W = $clog2(TASK_SLOTS + 1);
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int ID_W    = 7;

   // request codes
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_ADD    = 3'd1;
   localparam logic [2:0] REQ_REMOVE = 3'd2;
   localparam logic [2:0] REQ_ENABLE = 3'd3;
   localparam logic [2:0] REQ_RUN    = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_FIRED     = 3'd0;
   localparam logic [2:0] KIND_ADDED     = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_FULL      = 3'd4;
   localparam logic [2:0] KIND_IDLE      = 3'd5;

   typedef struct packed {
      logic [2:0]      req_type;
      logic [31:0]     current_time;
      logic [ID_W-1:0] task_ident;
      logic [15:0]     period_seconds;
      logic            enable_value;
   } ptt_req_type;

   typedef struct packed {
      logic [2:0]      result_kind;
      logic [ID_W-1:0] result_task;
      logic [31:0]     fire_count;
      logic            last_of_run;
   } ptt_rsp_type;

   // one table entry, one RAM word
   typedef struct packed {
      logic [15:0] period;
      logic [31:0] due_time;
      logic        enabled;
      logic [31:0] runs;
   } ptt_entry_type;

   localparam int ENTRY_W = $bits(ptt_entry_type);

endpackage

### rtl/core/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/periodic_task_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table_core
// Table of periodic tasks kept in one RAM, driven by tick and admin requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel carrying one request beat (tick, add,
//   remove, set enable, run now) with the current time. rsp_* returns one or
//   more result beats per request; last_of_run marks the final beat.
//   One request is worked at a time; req_ready is high only while idle.
//   Add, bad id and unused codes go from idle straight to the flush state;
//   remove, set enable and run now first do one RAM read and one write back.
//   A tick walks the occupied slots one per cycle through the table RAM
//   (read of slot i+1 overlaps the write back of slot i) while no output
//   stall holds the walk.
//   Fired results are held one beat back so the last one can be flagged.
//   Reset clears the task count and the control state; RAM contents are
//   never read before written, so no clearing pass is done.
//   When rsp_ready is low the result register holds its beat and the walk
//   stalls only when it has a second beat to hand over.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ptt_pkg::ptt_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ptt_pkg::ptt_rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RMW   = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   ptt_pkg::ptt_req_type  req_ff, req_in;
   logic [ptt_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [ptt_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ptt_pkg::TOTAL_W-1:0] total_ff, total_in;
   ptt_pkg::ptt_rsp_type  hold_ff, hold_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ptt_pkg::ptt_rsp_type  rsp_data_ff, rsp_data_in;

   // table RAM ports
   logic                        ram_we, ram_re;
   logic [ptt_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
   ptt_pkg::ptt_entry_type      ram_wdata, ram_rdata;
   logic [ptt_pkg::ENTRY_W-1:0] ram_rdata_raw;

   logic                   out_free;
   logic                   found;
   logic [ptt_pkg::ID_W-1:0] ident_m1;
   logic                   fire, report, stall, last_slot;

   ptt_ram #(
      .WIDTH (ptt_pkg::ENTRY_W),
      .DEPTH (ptt_pkg::TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = ptt_pkg::ptt_entry_type'(ram_rdata_raw);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // id lookup on the incoming beat: ids run 1..task_total
   assign ident_m1 = req_data.task_ident - 1'b1;
   assign found    = (req_data.task_ident != '0) &&
                     (req_data.task_ident <= ptt_pkg::ID_W'(total_ff));

   // walk decisions on the entry just read
   assign fire      = ram_rdata.enabled && (req_ff.current_time >= ram_rdata.due_time);
   assign report    = fire && (count_ff < ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS));
   assign stall     = report && hold_valid_ff && !out_free;
   assign last_slot = (ptt_pkg::TOTAL_W'(idx_ff) + 1'b1) == total_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in        = req_data;
               count_in      = '0;
               hold_valid_in = 1'b1;
               hold_in       = '{result_kind: ptt_pkg::KIND_NOT_FOUND,
                                 result_task: '0, fire_count: '0, last_of_run: 1'b1};
               idx_in        = ident_m1[ptt_pkg::IDX_W-1:0];
               state_in      = ST_FLUSH;
               unique case (req_data.req_type) inside
                  ptt_pkg::REQ_TICK: begin
                     hold_valid_in = 1'b0;
                     if (total_ff != '0) begin
                        idx_in    = '0;
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        state_in  = ST_WALK;
                     end
                  end
                  ptt_pkg::REQ_ADD: begin
                     if (total_ff >= ptt_pkg::TOTAL_W'(ptt_pkg::TASK_SLOTS)) begin
                        hold_in.result_kind = ptt_pkg::KIND_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = total_ff[ptt_pkg::IDX_W-1:0];
                        ram_wdata = '{period: req_data.period_seconds,
                                      due_time: req_data.current_time +
                                                32'(req_data.period_seconds),
                                      enabled: 1'b1, runs: '0};
                        total_in  = total_ff + 1'b1;
                        hold_in.result_kind = ptt_pkg::KIND_ADDED;
                        hold_in.result_task = ptt_pkg::ID_W'(total_ff) + 1'b1;
                     end
                  end
                  ptt_pkg::REQ_REMOVE, ptt_pkg::REQ_ENABLE, ptt_pkg::REQ_RUN: begin
                     if (found) begin
                        ram_re    = 1'b1;
                        ram_raddr = ident_m1[ptt_pkg::IDX_W-1:0];
                        state_in  = ST_RMW;
                     end
                  end
                  default: begin
                     // unused codes report not found
                  end
               endcase
            end
         end

         ST_RMW: begin
            ram_we   = 1'b1;
            state_in = ST_FLUSH;
            if (req_ff.req_type == ptt_pkg::REQ_RUN) begin
               ram_wdata.runs      = ram_rdata.runs + 1'b1;
               hold_in.result_kind = ptt_pkg::KIND_FIRED;
               hold_in.result_task = req_ff.task_ident;
               hold_in.fire_count  = ram_rdata.runs + 1'b1;
            end else begin
               ram_wdata.enabled   = (req_ff.req_type == ptt_pkg::REQ_ENABLE) &&
                                     req_ff.enable_value;
               hold_in.result_kind = ptt_pkg::KIND_DONE;
            end
         end

         ST_WALK: begin
            if (!stall) begin
               if (fire) begin
                  ram_we             = 1'b1;
                  ram_wdata.due_time = req_ff.current_time + 32'(ram_rdata.period);
                  ram_wdata.runs     = ram_rdata.runs + 1'b1;
               end
               if (report) begin
                  // previous firing leaves now, known not to be the last
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = hold_ff;
                     rsp_data_in.last_of_run = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_in = '{result_kind: ptt_pkg::KIND_FIRED,
                              result_task: ptt_pkg::ID_W'(idx_ff) + 1'b1,
                              fire_count: ram_rdata.runs + 1'b1, last_of_run: 1'b1};
                  count_in = count_ff + 1'b1;
               end
               if (last_slot) begin
                  state_in = ST_FLUSH;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_data_in = hold_ff;
               end else begin
                  rsp_data_in = '{result_kind: ptt_pkg::KIND_IDLE, result_task: '0,
                                  fire_count: '0, last_of_run: 1'b1};
               end
               rsp_data_in.last_of_run = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the periodic task timer table, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input ptt_pkg::ptt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ptt_pkg::ptt_rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_kind <= ptt_pkg::KIND_IDLE)
      else $error("bad result kind");

   // only fired beats can be non-final; other beats carry no count, and no id but for added
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != ptt_pkg::KIND_FIRED |->
         rsp_data.last_of_run && rsp_data.fire_count == '0 &&
         (rsp_data.result_task == '0 || rsp_data.result_kind == ptt_pkg::KIND_ADDED))
      else $error("malformed status beat");

endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### test/tb_periodic_task_timer_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table_core
// Self-checking bench for the periodic task timer table core: a queue-fed
// driver sends request beats, a shadow copy of the task table predicts every
// result beat, and a monitor compares each accepted beat in order.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table_core;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ptt_pkg::ptt_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ptt_pkg::ptt_rsp_type rsp_data;

   // requests waiting for the driver, result beats waiting for the monitor
   ptt_pkg::ptt_req_type stim_q[$];
   ptt_pkg::ptt_rsp_type awaited_results[$];

   // shadow of the task table
   int          sched_total = 0;
   logic [15:0] slot_period  [ptt_pkg::TASK_SLOTS];
   logic [31:0] slot_due     [ptt_pkg::TASK_SLOTS];
   logic        slot_enabled [ptt_pkg::TASK_SLOTS];
   logic [31:0] slot_runs    [ptt_pkg::TASK_SLOTS];

   int          send_idle_pct = 17;
   int          recv_idle_pct = 68;
   int          mismatch_count = 0;
   bit          req_beat_taken = 1'b0;

   periodic_task_timer_table_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic ptt_pkg::ptt_rsp_type rsp_beat(logic [2:0] kind, int id,
                                                     logic [31:0] count, bit last);
      ptt_pkg::ptt_rsp_type b;
      b.result_kind = kind;
      b.result_task = ptt_pkg::ID_W'(id);
      b.fire_count  = count;
      b.last_of_run = last;
      return b;
   endfunction

   // Work one request against the shadow table and queue the beats it causes.
   task automatic apply_request(input ptt_pkg::ptt_req_type r);
      ptt_pkg::ptt_rsp_type run_q[$];
      bit          hit;
      int          slot;
      hit  = (r.task_ident >= 1) && (r.task_ident <= sched_total);
      slot = hit ? int'(r.task_ident) - 1 : 0;
      case (r.req_type) inside
         ptt_pkg::REQ_TICK: begin
            // walk occupied slots in order, due means now >= due time
            for (int i = 0; i < sched_total; i++) begin
               if (slot_enabled[i] && r.current_time >= slot_due[i]) begin
                  slot_runs[i] = slot_runs[i] + 32'd1;
                  slot_due[i]  = r.current_time + 32'(slot_period[i]);
                  if (run_q.size() < ptt_pkg::MAX_RESULTS)
                     run_q.push_back(rsp_beat(ptt_pkg::KIND_FIRED, i + 1,
                                              slot_runs[i], 1'b0));
               end
            end
            if (run_q.size() == 0)
               run_q.push_back(rsp_beat(ptt_pkg::KIND_IDLE, 0, '0, 1'b1));
            else
               run_q[run_q.size() - 1].last_of_run = 1'b1;
         end
         ptt_pkg::REQ_ADD: begin
            if (sched_total >= ptt_pkg::TASK_SLOTS) begin
               run_q.push_back(rsp_beat(ptt_pkg::KIND_FULL, 0, '0, 1'b1));
            end else begin
               slot_period[sched_total]  = r.period_seconds;
               slot_due[sched_total]     = r.current_time + 32'(r.period_seconds);
               slot_enabled[sched_total] = 1'b1;
               slot_runs[sched_total]    = '0;
               sched_total++;
               run_q.push_back(rsp_beat(ptt_pkg::KIND_ADDED, sched_total, '0, 1'b1));
            end
         end
         ptt_pkg::REQ_REMOVE, ptt_pkg::REQ_ENABLE: begin
            if (!hit) begin
               run_q.push_back(rsp_beat(ptt_pkg::KIND_NOT_FOUND, 0, '0, 1'b1));
            end else begin
               slot_enabled[slot] = (r.req_type == ptt_pkg::REQ_REMOVE) ? 1'b0 :
                                    r.enable_value;
               run_q.push_back(rsp_beat(ptt_pkg::KIND_DONE, 0, '0, 1'b1));
            end
         end
         ptt_pkg::REQ_RUN: begin
            // fires regardless of enable, due time untouched
            if (!hit) begin
               run_q.push_back(rsp_beat(ptt_pkg::KIND_NOT_FOUND, 0, '0, 1'b1));
            end else begin
               slot_runs[slot] = slot_runs[slot] + 32'd1;
               run_q.push_back(rsp_beat(ptt_pkg::KIND_FIRED, int'(r.task_ident),
                                        slot_runs[slot], 1'b1));
            end
         end
         default: begin
            // unused request codes
            run_q.push_back(rsp_beat(ptt_pkg::KIND_NOT_FOUND, 0, '0, 1'b1));
         end
      endcase
      foreach (run_q[k])
         awaited_results.push_back(run_q[k]);
   endtask

   task automatic queue_request(input logic [2:0] kind, input logic [31:0] t,
                                input int id, input logic [15:0] per,
                                input logic en);
      ptt_pkg::ptt_req_type r;
      r.req_type       = kind;
      r.current_time   = t;
      r.task_ident     = ptt_pkg::ID_W'(id);
      r.period_seconds = per;
      r.enable_value   = en;
      stim_q.push_back(r);
   endtask

   // Sample both channels at the rising edge: book accepted requests into
   // the shadow table, check accepted result beats against the oldest one.
   always @(posedge clock) begin
      ptt_pkg::ptt_rsp_type exp_beat;
      if (!reset && req_valid && req_ready) begin
         apply_request(req_data);
         req_beat_taken = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result beat kind %0d task %0d",
                   rsp_data.result_kind, rsp_data.result_task);
            mismatch_count++;
         end else begin
            exp_beat = awaited_results.pop_front();
            if (rsp_data.result_kind !== exp_beat.result_kind) begin
               $error("result_kind expected %0d actual %0d",
                      exp_beat.result_kind, rsp_data.result_kind);
               mismatch_count++;
            end
            if (rsp_data.result_task !== exp_beat.result_task) begin
               $error("result_task expected %0d actual %0d",
                      exp_beat.result_task, rsp_data.result_task);
               mismatch_count++;
            end
            if (rsp_data.fire_count !== exp_beat.fire_count) begin
               $error("fire_count expected %0d actual %0d",
                      exp_beat.fire_count, rsp_data.fire_count);
               mismatch_count++;
            end
            if (rsp_data.last_of_run !== exp_beat.last_of_run) begin
               $error("last_of_run expected %0d actual %0d",
                      exp_beat.last_of_run, rsp_data.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // Drive at the falling edge. A beat stays up with its payload until the
   // rising edge has taken it; a new one may follow in the very next cycle.
   always @(negedge clock) begin
      bit hold_beat;
      hold_beat      = req_valid && !req_beat_taken;
      req_beat_taken = 1'b0;
      if (!reset && !hold_beat && stim_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         req_data  <= stim_q.pop_front();
         hold_beat  = 1'b1;
      end
      req_valid <= hold_beat;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Stimulus and end of run
   initial begin
      logic [31:0]          now;
      ptt_pkg::ptt_req_type item;
      int                   pick;
      int                   roll;

      // directed: empty table, bad ids, unused codes, period and time extremes
      queue_request(ptt_pkg::REQ_TICK,   32'd0,         0,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_REMOVE, 32'd0,         1,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_RUN,    32'd0,         0,   16'hFFFF, 1'b1);
      queue_request(3'd5,                32'hFFFF_FFFF, 127, 16'hFFFF, 1'b1);
      queue_request(3'd6,                32'd0,         1,   16'd0,    1'b0);
      queue_request(3'd7,                32'h5A5A_A5A5, 64,  16'h5A5A, 1'b1);
      queue_request(ptt_pkg::REQ_ADD,    32'd100,       0,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_ADD,    32'd100,       127, 16'hFFFF, 1'b1);
      // due time wraps past the top of the 32-bit range
      queue_request(ptt_pkg::REQ_ADD,    32'hFFFF_FFFE, 0,   16'd5,    1'b0);
      queue_request(ptt_pkg::REQ_TICK,   32'd100,       0,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_ENABLE, 32'd100,       1,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_TICK,   32'd105,       0,   16'd0,    1'b0);
      // run now on a disabled task still fires
      queue_request(ptt_pkg::REQ_RUN,    32'd105,       1,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_ENABLE, 32'd105,       1,   16'd0,    1'b1);
      queue_request(ptt_pkg::REQ_REMOVE, 32'd105,       2,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_ENABLE, 32'd105,       127, 16'd0,    1'b1);
      queue_request(ptt_pkg::REQ_ENABLE, 32'd105,       4,   16'd0,    1'b1);
      queue_request(ptt_pkg::REQ_RUN,    32'd105,       64,  16'd0,    1'b1);
      queue_request(ptt_pkg::REQ_TICK,   32'hFFFF_FFFF, 0,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_RUN,    32'hFFFF_FFFF, 3,   16'd0,    1'b0);
      queue_request(ptt_pkg::REQ_TICK,   32'd50,        0,   16'd0,    1'b0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      now = 32'd1000;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < 160; n++) begin
            while (stim_q.size() >= 2) @(posedge clock);
            pick = $urandom_range(99);
            roll = $urandom_range(99);
            item.current_time   = (roll < 10) ? $urandom() : now;
            item.task_ident     = ptt_pkg::ID_W'($urandom_range(0, 127));
            item.period_seconds = 16'($urandom());
            item.enable_value   = 1'($urandom());
            // mostly address a task that exists
            if (sched_total > 0 && $urandom_range(99) < 85)
               item.task_ident = ptt_pkg::ID_W'($urandom_range(1, sched_total));
            if (pick < 40) begin
               item.req_type = ptt_pkg::REQ_TICK;
               // 0 to 4 seconds per tick, now and then a jump anywhere or to the top
               if (roll < 4)
                  now = $urandom();
               else if (roll < 6)
                  now = 32'hFFFF_FFFF;
               else
                  now = now + 32'($urandom_range(0, 4));
               item.current_time = now;
            end else if (pick < 55) begin
               item.req_type = ptt_pkg::REQ_ADD;
               if (roll < 70)
                  item.period_seconds = 16'($urandom_range(0, 6));
               else if (roll < 80)
                  item.period_seconds = (roll < 75) ? 16'hFFFF : 16'd0;
            end else if (pick < 65) begin
               item.req_type = ptt_pkg::REQ_REMOVE;
            end else if (pick < 80) begin
               item.req_type = ptt_pkg::REQ_ENABLE;
               // lean toward enabling so ticks keep finding work
               if (roll < 50)
                  item.enable_value = 1'b1;
            end else if (pick < 92) begin
               item.req_type = ptt_pkg::REQ_RUN;
            end else begin
               item.req_type = 3'($urandom_range(5, 7));
            end
            stim_q.push_back(item);
         end
         while (stim_q.size() != 0 || req_valid) @(posedge clock);
      end

      while (awaited_results.size() != 0) @(posedge clock);
      // let any stray beat surface
      repeat (2 * ptt_pkg::TASK_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("PASS periodic_task_timer_table_core");
      else
         $display("FAIL periodic_task_timer_table_core");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("FAIL periodic_task_timer_table_core");
      $finish;
   end

endmodule
